>>> src/aie_pkg.sv
// Package for the instruction encoder: payload structs, op and error codes,
// opcode tables and queue sizing. No dependencies.
`default_nettype none

package aie_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_MULTIPLY   = 1'd1;

  localparam int ADDR_W = 22;

  // Queue between front and back (power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Mnemonic indexes that bound the instruction groups
  localparam logic [6:0] OP_LAST_PLAIN = 7'd24;
  localparam logic [6:0] OP_BCLR       = 7'd26;
  localparam logic [6:0] OP_SER        = 7'd27;
  localparam logic [6:0] OP_TST        = 7'd38;
  localparam logic [6:0] OP_ROL        = 7'd41;
  localparam logic [6:0] OP_BRLAST     = 7'd59;
  localparam logic [6:0] OP_RCALL      = 7'd61;
  localparam logic [6:0] OP_CALL       = 7'd63;
  localparam logic [6:0] OP_BRBC       = 7'd65;
  localparam logic [6:0] OP_MUL        = 7'd77;
  localparam logic [6:0] OP_SBIW       = 7'd79;
  localparam logic [6:0] OP_CBR        = 7'd87;
  localparam logic [6:0] OP_BLD        = 7'd91;
  localparam logic [6:0] OP_OUT        = 7'd93;
  localparam logic [6:0] OP_CBI        = 7'd97;
  localparam logic [6:0] OP_STS        = 7'd99;
  localparam logic [6:0] OP_LD         = 7'd100;
  localparam logic [6:0] OP_ST         = 7'd101;
  localparam logic [6:0] OP_LDD        = 7'd102;
  localparam logic [6:0] OP_STD        = 7'd103;

  // Error codes
  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_HIGHREG = 4'd1;
  localparam logic [3:0] ERR_BRANCH  = 4'd2;
  localparam logic [3:0] ERR_RJMP    = 4'd3;
  localparam logic [3:0] ERR_ABS     = 4'd4;
  localparam logic [3:0] ERR_BITNUM  = 4'd5;
  localparam logic [3:0] ERR_MUL     = 4'd6;
  localparam logic [3:0] ERR_WORDREG = 4'd7;
  localparam logic [3:0] ERR_CONST6  = 4'd8;
  localparam logic [3:0] ERR_IMM8    = 4'd9;
  localparam logic [3:0] ERR_IO6     = 4'd10;
  localparam logic [3:0] ERR_IO5     = 4'd11;
  localparam logic [3:0] ERR_SRAM    = 4'd12;

  // Instruction group decided by the front end
  typedef enum logic [4:0] {
    CL_NONE,
    CL_PLAIN,
    CL_SFLAG,
    CL_ONEREG,
    CL_BRANCH,
    CL_RJUMP,
    CL_ABS,
    CL_BRBIT,
    CL_TWOREG,
    CL_WORDIMM,
    CL_IMM8,
    CL_REGBIT,
    CL_IO6,
    CL_IO5,
    CL_SRAM,
    CL_LD,
    CL_ST,
    CL_DISP
  } aie_cls_e;

  typedef struct packed {
    logic [6:0]         op;
    logic [4:0]         data_reg;
    logic [4:0]         source_reg;
    logic [3:0]         bit_num;
    logic signed [31:0] value;
    logic [3:0]         pointer_mode;
    logic               use_z;
  } aie_in_t;

  typedef struct packed {
    logic [15:0]       first_word;
    logic [15:0]       second_word;
    logic              is_long;
    logic              emitted;
    logic [ADDR_W-1:0] word_address;
    logic [3:0]        error;
  } aie_out_t;

  // Range checks on the value, done at the front
  typedef struct packed {
    logic rel7_ok;
    logic rel12_ok;
    logic abs22_ok;
    logic u6_ok;
    logic u5_ok;
    logic u16_ok;
    logic imm8_ok;
  } aie_chk_t;

  // One classified request in the queue
  typedef struct packed {
    aie_cls_e          cls;
    logic [6:0]        op;
    logic [4:0]        data_reg;
    logic [4:0]        source_reg;
    logic [2:0]        bit_lo;
    logic [21:0]       vlo;
    logic [3:0]        pm;
    logic              use_z;
    logic [ADDR_W-1:0] addr;
    logic [11:0]       rel;
    aie_chk_t          chk;
    logic              emit;
  } aie_item_t;

  localparam logic [15:0] BASE_WORD [128] = '{
    16'h0000,16'h9408,16'h9488,16'h9428,16'h94a8,16'h9418,16'h9498,16'h9478,
    16'h94f8,16'h9448,16'h94c8,16'h9438,16'h94b8,16'h9468,16'h94e8,16'h9458,
    16'h94d8,16'h9588,16'h95a8,16'h9409,16'h9509,16'h9508,16'h9518,16'h95c8,
    16'h95d8,16'h9408,16'h9488,16'hef0f,16'h9400,16'h9401,16'h9403,16'h940a,
    16'h9406,16'h9407,16'h9405,16'h9402,16'h920f,16'h900f,16'h2000,16'h2400,
    16'h0c00,16'h1c00,16'hf001,16'hf401,16'hf000,16'hf400,16'hf400,16'hf000,
    16'hf002,16'hf402,16'hf404,16'hf004,16'hf005,16'hf405,16'hf006,16'hf406,
    16'hf003,16'hf403,16'hf007,16'hf407,16'hc000,16'hd000,16'h940c,16'h940e,
    16'hf000,16'hf400,16'h0c00,16'h1c00,16'h1800,16'h0800,16'h2000,16'h2800,
    16'h2400,16'h1400,16'h0400,16'h1000,16'h2c00,16'h9c00,16'h9600,16'h9700,
    16'h5000,16'h4000,16'h7000,16'h6000,16'h6000,16'h3000,16'he000,16'h7000,
    16'hfc00,16'hfe00,16'hfa00,16'hf800,16'hb000,16'hb800,16'h9900,16'h9b00,
    16'h9a00,16'h9800,16'h9000,16'h9200,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000
  };

  // Pointer modes X,X+,-X,Y,Y+,-Y,Z,Z+,-Z; unused codes never index here
  localparam logic [15:0] LOAD_WORD [16] = '{
    16'h900c,16'h900d,16'h900e,16'h8008,16'h9009,16'h900a,16'h8000,16'h9001,
    16'h9002,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000
  };
  localparam logic [15:0] STORE_WORD [16] = '{
    16'h920c,16'h920d,16'h920e,16'h8208,16'h9209,16'h920a,16'h8200,16'h9201,
    16'h9202,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000
  };

endpackage

`default_nettype wire

>>> src/aie_front.sv
// Front end: takes requests, sorts them into groups, runs the range checks
// and hands out code addresses. Depends on aie_pkg.
`default_nettype none

module aie_front import aie_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire aie_in_t               in_data_i,
  output logic                       in_stall_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output aie_item_t                  item_o
);

  logic [ADDR_W-1:0] code_addr_q, code_addr_d;
  logic              accept;
  aie_cls_e          cls;
  logic [6:0]        op;
  logic              bit_bad;
  logic              emit;
  logic              long_ins;
  logic signed [33:0] rel_full;
  logic signed [31:0] v;

  assign op     = in_data_i.op;
  assign v      = in_data_i.value;
  assign accept = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o = accept;

  always_comb begin
    if (op <= OP_LAST_PLAIN)  cls = CL_PLAIN;
    else if (op <= OP_BCLR)   cls = CL_SFLAG;
    else if (op <= OP_ROL)    cls = CL_ONEREG;
    else if (op <= OP_BRLAST) cls = CL_BRANCH;
    else if (op <= OP_RCALL)  cls = CL_RJUMP;
    else if (op <= OP_CALL)   cls = CL_ABS;
    else if (op <= OP_BRBC)   cls = CL_BRBIT;
    else if (op <= OP_MUL)    cls = CL_TWOREG;
    else if (op <= OP_SBIW)   cls = CL_WORDIMM;
    else if (op <= OP_CBR)    cls = CL_IMM8;
    else if (op <= OP_BLD)    cls = CL_REGBIT;
    else if (op <= OP_OUT)    cls = CL_IO6;
    else if (op <= OP_CBI)    cls = CL_IO5;
    else if (op <= OP_STS)    cls = CL_SRAM;
    else if (op == OP_LD)     cls = CL_LD;
    else if (op == OP_ST)     cls = CL_ST;
    else if (op <= OP_STD)    cls = CL_DISP;
    else                      cls = CL_NONE;
  end

  // Groups that carry a bit number drop the instruction when it is above 7
  assign bit_bad  = in_data_i.bit_num[3] &&
                    (cls == CL_SFLAG || cls == CL_BRBIT || cls == CL_REGBIT ||
                     cls == CL_IO5);
  assign emit     = !bit_bad;
  assign long_ins = (cls == CL_ABS) || (cls == CL_SRAM);

  // Relative target against address+1
  assign rel_full = $signed({{2{v[31]}}, v}) -
                    $signed({{(34-ADDR_W){1'b0}}, code_addr_q}) - 34'sd1;

  always_comb begin
    item_o.cls        = cls;
    item_o.op         = op;
    item_o.data_reg   = in_data_i.data_reg;
    item_o.source_reg = in_data_i.source_reg;
    item_o.bit_lo     = in_data_i.bit_num[2:0];
    item_o.vlo        = v[21:0];
    item_o.pm         = (in_data_i.pointer_mode > 4'd8) ? 4'd0 : in_data_i.pointer_mode;
    item_o.use_z      = in_data_i.use_z;
    item_o.addr       = code_addr_q;
    item_o.rel        = rel_full[11:0];
    item_o.chk.rel7_ok  = (rel_full >= -34'sd64) && (rel_full <= 34'sd63);
    item_o.chk.rel12_ok = (rel_full >= -34'sd2048) && (rel_full <= 34'sd2047);
    item_o.chk.abs22_ok = !v[31] && (v[30:22] == '0);
    item_o.chk.u6_ok    = !v[31] && (v[30:6] == '0);
    item_o.chk.u5_ok    = !v[31] && (v[30:5] == '0);
    item_o.chk.u16_ok   = !v[31] && (v[30:16] == '0);
    item_o.chk.imm8_ok  = (v >= -32'sd128) && (v <= 32'sd255);
    item_o.emit       = emit;
  end

  always_comb begin
    code_addr_d = code_addr_q;
    if (cfg_we_i && cfg_index_i == CFG_START_ADDRESS) begin
      code_addr_d = cfg_wdata_i[ADDR_W-1:0];
    end else if (accept && cls != CL_NONE && emit) begin
      code_addr_d = code_addr_q + (long_ins ? ADDR_W'(2) : ADDR_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_addr_q <= '0;
    end else begin
      code_addr_q <= code_addr_d;
    end
  end

  // Address moves only on a config write or an accepted request
  a_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept && !cfg_we_i) |=> $stable(code_addr_q))
    else $error("code address changed without a request");

  // A suppressed or unknown instruction leaves the address alone
  a_no_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && (cls == CL_NONE || !emit)) |=> $stable(code_addr_q))
    else $error("code address advanced for a dropped instruction");

endmodule

`default_nettype wire

>>> src/aie_queue.sv
// Short queue between front and back end, held in flops.
// Depends on aie_pkg for the item type and the depth.
`default_nettype none

module aie_queue import aie_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire aie_item_t push_item_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           nonempty_o,
  output aie_item_t      head_o
);

  aie_item_t       entry_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == Q_CW'(Q_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !nonempty_o))
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> src/aie_back.sv
// Back end: packs opcode words from a classified request and holds the
// result in an output register. Depends on aie_pkg.
`default_nettype none

module aie_back import aie_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  q_nonempty_i,
  input  wire aie_item_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output aie_out_t                   out_data_o
);

  logic        no_mul_q;
  logic        out_valid_q, out_valid_d;
  aie_out_t    out_q, res;
  logic [15:0] w1, w2;
  logic [3:0]  err;
  logic        lng;
  logic [7:0]  k;
  logic [4:0]  d, s;
  logic [2:0]  b;
  logic [21:0] v;

  assign d = head_i.data_reg;
  assign s = head_i.source_reg;
  assign b = head_i.bit_lo;
  assign v = head_i.vlo;
  assign k = (head_i.op == OP_CBR) ? ~v[7:0] : v[7:0];

  always_comb begin
    w1  = '0;
    w2  = '0;
    err = ERR_NONE;
    lng = 1'b0;
    case (head_i.cls)
      CL_PLAIN: begin
        w1 = '0;
      end
      CL_SFLAG: begin
        w1 = {9'd0, b, 4'd0};
      end
      CL_ONEREG: begin
        if (head_i.op == OP_SER && !d[4]) err = ERR_HIGHREG;
        w1 = {7'd0, d, 4'd0};
        if (head_i.op >= OP_TST) w1 = w1 | {6'd0, d[4], 5'd0, d[3:0]};
      end
      CL_BRANCH: begin
        if (!head_i.chk.rel7_ok) err = ERR_BRANCH;
        w1 = {6'd0, head_i.rel[6:0], 3'd0};
      end
      CL_RJUMP: begin
        if (!head_i.chk.rel12_ok) err = ERR_RJMP;
        w1 = {4'd0, head_i.rel};
      end
      CL_ABS: begin
        if (!head_i.chk.abs22_ok) err = ERR_ABS;
        w1  = {7'd0, v[21:17], 3'd0, v[16]};
        w2  = v[15:0];
        lng = 1'b1;
      end
      CL_BRBIT: begin
        if (!head_i.chk.rel7_ok) err = ERR_BRANCH;
        w1 = {6'd0, head_i.rel[6:0], b};
      end
      CL_TWOREG: begin
        if (head_i.op == OP_MUL && no_mul_q) err = ERR_MUL;
        w1 = {6'd0, s[4], d, s[3:0]};
      end
      CL_WORDIMM: begin
        // pair register must be r24, r26, r28 or r30
        if (!(d[4:3] == 2'b11 && !d[0])) err = ERR_WORDREG;
        if (!head_i.chk.u6_ok && err == ERR_NONE) err = ERR_CONST6;
        w1 = {8'd0, v[5:4], d[2:1], v[3:0]};
      end
      CL_IMM8: begin
        if (!d[4]) err = ERR_HIGHREG;
        if (!head_i.chk.imm8_ok && err == ERR_NONE) err = ERR_IMM8;
        w1 = {4'd0, k[7:4], d[3:0], k[3:0]};
      end
      CL_REGBIT: begin
        w1 = {7'd0, d, 1'b0, b};
      end
      CL_IO6: begin
        if (!head_i.chk.u6_ok) err = ERR_IO6;
        w1 = {5'd0, v[5:4], d, v[3:0]};
      end
      CL_IO5: begin
        if (!head_i.chk.u5_ok) err = ERR_IO5;
        w1 = {8'd0, v[4:0], b};
      end
      CL_SRAM: begin
        if (!head_i.chk.u16_ok) err = ERR_SRAM;
        w1  = {7'd0, d, 4'd0};
        w2  = v[15:0];
        lng = 1'b1;
      end
      CL_LD: begin
        w1 = {7'd0, d, 4'd0} | LOAD_WORD[head_i.pm];
      end
      CL_ST: begin
        w1 = {7'd0, d, 4'd0} | STORE_WORD[head_i.pm];
      end
      CL_DISP: begin
        if (!head_i.chk.u6_ok) err = ERR_SRAM;
        w1 = {2'd0, v[5], 1'b0, v[4:3], 1'b0, d, 1'b0, v[2:0]};
        if (head_i.op == OP_LDD) w1 = w1 | (head_i.use_z ? 16'h8000 : 16'h8008);
        else                     w1 = w1 | (head_i.use_z ? 16'h8200 : 16'h8208);
      end
      default: begin
        w1 = '0;
      end
    endcase
  end

  always_comb begin
    res.word_address = head_i.addr;
    res.first_word   = '0;
    res.second_word  = '0;
    res.is_long      = 1'b0;
    res.emitted      = 1'b0;
    res.error        = ERR_NONE;
    if (head_i.cls != CL_NONE) begin
      if (!head_i.emit) begin
        res.error = ERR_BITNUM;
      end else begin
        res.first_word  = w1 | BASE_WORD[head_i.op];
        res.second_word = lng ? w2 : 16'd0;
        res.is_long     = lng;
        res.emitted     = 1'b1;
        res.error       = err;
      end
    end
  end

  // Take from the queue whenever the output register is free or draining
  assign pop_o = q_nonempty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      no_mul_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == CFG_NO_MULTIPLY) begin
        no_mul_q <= cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_long_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_long) |-> out_q.emitted)
    else $error("long result without emitted word");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.emitted) |->
      (out_q.first_word == 16'd0 && out_q.second_word == 16'd0 &&
       (out_q.error == ERR_BITNUM || out_q.error == ERR_NONE)))
    else $error("dropped instruction carries words");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

>>> src/avr_instruction_encoder_unit.sv
// Instruction encoder, top level: front end, queue and back end.
// Depends on aie_pkg, aie_front, aie_queue and aie_back.
//
// Use: each request on the input channel (in_valid_i / in_stall_o / in_data_i)
// is one tokenized instruction. Each yields exactly one result on the output
// channel (out_valid_o / out_stall_i / out_data_o): the opcode word, the
// extension word of long instructions, the code address and an error code.
// Flow: a request is classified and written into the queue when it is taken;
// the back end then packs it from the queue head into the output register,
// which offers its result. Throughput is one request per cycle while the
// queue is not full, set by the front end and the single output register.
// The front end keeps the code address, so the queue never waits on the
// back end for address updates.
// Stalls: a two-entry queue sits between the front and back end; when the
// receiver stalls the result holds, the queue fills, and in_stall_o rises
// once both entries are taken.
// Reset: code address and the multiply-disable flag clear to 0, queue and
// output register empty. Writing start_address loads the code address.
`default_nettype none

module avr_instruction_encoder_unit import aie_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire aie_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output aie_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic      push, pop, q_full, q_nonempty;
  aie_item_t push_item, head_item;

  aie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  aie_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .nonempty_o  (q_nonempty),
    .head_o      (head_item)
  );

  aie_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_nonempty_i (q_nonempty),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

>>> bench/aie_result_check.sv
// Result checker for the instruction encoder: watches both channels and the
// configuration port, predicts each opcode result and compares it in order.
// Depends on aie_pkg for the payload structs, config indexes and codes.

module aie_result_check import aie_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_stall_i,
  input  aie_in_t               req_i,
  input  logic                  res_valid_i,
  input  logic                  res_stall_i,
  input  aie_out_t              res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam logic [15:0] OP_WORD [104] = '{
    16'h0000,16'h9408,16'h9488,16'h9428,16'h94a8,16'h9418,16'h9498,16'h9478,
    16'h94f8,16'h9448,16'h94c8,16'h9438,16'h94b8,16'h9468,16'h94e8,16'h9458,
    16'h94d8,16'h9588,16'h95a8,16'h9409,16'h9509,16'h9508,16'h9518,16'h95c8,
    16'h95d8,16'h9408,16'h9488,16'hef0f,16'h9400,16'h9401,16'h9403,16'h940a,
    16'h9406,16'h9407,16'h9405,16'h9402,16'h920f,16'h900f,16'h2000,16'h2400,
    16'h0c00,16'h1c00,16'hf001,16'hf401,16'hf000,16'hf400,16'hf400,16'hf000,
    16'hf002,16'hf402,16'hf404,16'hf004,16'hf005,16'hf405,16'hf006,16'hf406,
    16'hf003,16'hf403,16'hf007,16'hf407,16'hc000,16'hd000,16'h940c,16'h940e,
    16'hf000,16'hf400,16'h0c00,16'h1c00,16'h1800,16'h0800,16'h2000,16'h2800,
    16'h2400,16'h1400,16'h0400,16'h1000,16'h2c00,16'h9c00,16'h9600,16'h9700,
    16'h5000,16'h4000,16'h7000,16'h6000,16'h6000,16'h3000,16'he000,16'h7000,
    16'hfc00,16'hfe00,16'hfa00,16'hf800,16'hb000,16'hb800,16'h9900,16'h9b00,
    16'h9a00,16'h9800,16'h9000,16'h9200,16'h0000,16'h0000,16'h0000,16'h0000
  };

  // X, X+, -X, Y, Y+, -Y, Z, Z+, -Z
  localparam logic [15:0] PTR_LOAD [9] = '{
    16'h900c,16'h900d,16'h900e,16'h8008,16'h9009,16'h900a,16'h8000,16'h9001,16'h9002
  };
  localparam logic [15:0] PTR_STORE [9] = '{
    16'h920c,16'h920d,16'h920e,16'h8208,16'h9209,16'h920a,16'h8200,16'h9201,16'h9202
  };

  logic [ADDR_W-1:0] code_addr = '0;
  logic              mul_off = 1'b0;
  aie_out_t          want_q[$];
  aie_out_t          want;
  int                fails = 0;
  int                waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  // the first range violation found sticks
  function automatic logic [3:0] first_err(input logic [3:0] cur, input logic [3:0] code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  function automatic aie_out_t encode_instr(input aie_in_t req, input logic [ADDR_W-1:0] pc,
                                            input logic no_mul);
    aie_out_t    res;
    longint      v;
    longint      rel;
    logic [31:0] vu;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] k;
    logic [6:0]  op;
    logic [4:0]  d;
    logic [4:0]  s;
    logic [3:0]  b;
    logic [3:0]  pm;
    logic [3:0]  err;
    logic        long_w;
    logic        emit;
    op     = req.op;
    d      = req.data_reg;
    s      = req.source_reg;
    b      = req.bit_num;
    pm     = (req.pointer_mode > 4'd8) ? 4'd0 : req.pointer_mode;
    vu     = req.value;
    v      = longint'($signed(req.value));
    rel    = v - longint'(pc) - 1;
    w1     = '0;
    w2     = '0;
    err    = ERR_NONE;
    long_w = 1'b0;
    emit   = 1'b1;
    res    = '0;
    res.word_address = pc;
    if (op > OP_STD) return res;

    if (op <= OP_LAST_PLAIN) begin
      w1 = '0;
    end else if (op <= OP_BCLR) begin
      emit = (b < 4'd8);
      w1   = 32'(b[2:0]) << 4;
    end else if (op <= OP_ROL) begin
      if (op == OP_SER && d < 5'd16) err = first_err(err, ERR_HIGHREG);
      w1 = 32'(d) << 4;
      if (op >= OP_TST) w1 |= (32'(d[4]) << 9) | 32'(d[3:0]);
    end else if (op <= OP_BRLAST) begin
      if (rel < -64 || rel > 63) err = first_err(err, ERR_BRANCH);
      w1 = 32'(rel[6:0]) << 3;
    end else if (op <= OP_RCALL) begin
      if (rel < -2048 || rel > 2047) err = first_err(err, ERR_RJMP);
      w1 = 32'(rel[11:0]);
    end else if (op <= OP_CALL) begin
      if (v < 0 || v > 4194303) err = first_err(err, ERR_ABS);
      w1     = (32'(vu[21:17]) << 4) | 32'(vu[16]);
      w2     = 32'(vu[15:0]);
      long_w = 1'b1;
    end else if (op <= OP_BRBC) begin
      emit = (b < 4'd8);
      if (rel < -64 || rel > 63) err = first_err(err, ERR_BRANCH);
      w1 = 32'(b[2:0]) | (32'(rel[6:0]) << 3);
    end else if (op <= OP_MUL) begin
      if (op == OP_MUL && no_mul) err = first_err(err, ERR_MUL);
      w1 = (32'(d) << 4) | (32'(s[4]) << 9) | 32'(s[3:0]);
    end else if (op <= OP_SBIW) begin
      // only r24, r26, r28, r30 start a word pair
      if (!(d[4:3] == 2'b11 && !d[0])) err = first_err(err, ERR_WORDREG);
      w1 = 32'(d[2:1]) << 4;
      if (v < 0 || v > 63) err = first_err(err, ERR_CONST6);
      w1 |= (32'(vu[5:4]) << 6) | 32'(vu[3:0]);
    end else if (op <= OP_CBR) begin
      if (d < 5'd16) err = first_err(err, ERR_HIGHREG);
      w1 = 32'(d[3:0]) << 4;
      if (v < -128 || v > 255) err = first_err(err, ERR_IMM8);
      k = (op == OP_CBR) ? ~vu : vu;
      w1 |= (32'(k[7:4]) << 8) | 32'(k[3:0]);
    end else if (op <= OP_BLD) begin
      emit = (b < 4'd8);
      w1   = (32'(d) << 4) | 32'(b[2:0]);
    end else if (op <= OP_OUT) begin
      if (v < 0 || v > 63) err = first_err(err, ERR_IO6);
      w1 = (32'(vu[5:4]) << 9) | 32'(vu[3:0]) | (32'(d) << 4);
    end else if (op <= OP_CBI) begin
      if (v < 0 || v > 31) err = first_err(err, ERR_IO5);
      emit = (b < 4'd8);
      w1   = (32'(vu[4:0]) << 3) | 32'(b[2:0]);
    end else if (op <= OP_STS) begin
      if (v < 0 || v > 65535) err = first_err(err, ERR_SRAM);
      w1     = 32'(d) << 4;
      w2     = 32'(vu[15:0]);
      long_w = 1'b1;
    end else if (op == OP_LD) begin
      w1 = (32'(d) << 4) | 32'(PTR_LOAD[pm]);
    end else if (op == OP_ST) begin
      w1 = (32'(d) << 4) | 32'(PTR_STORE[pm]);
    end else begin
      if (v < 0 || v > 63) err = first_err(err, ERR_SRAM);
      // displacement q scatters to bits 13, 11:10 and 2:0
      w1 = (32'(d) << 4) | (32'(vu[5]) << 13) | (32'(vu[4:3]) << 10) | 32'(vu[2:0]);
      if (op == OP_LDD) w1 |= req.use_z ? 32'h8000 : 32'h8008;
      else              w1 |= req.use_z ? 32'h8200 : 32'h8208;
    end

    if (!emit) begin
      res.error = ERR_BITNUM;
    end else begin
      res.first_word  = w1[15:0] | OP_WORD[op];
      res.second_word = long_w ? w2[15:0] : 16'h0000;
      res.is_long     = long_w;
      res.emitted     = 1'b1;
      res.error       = err;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_addr = '0;
      mul_off   = 1'b0;
      want_q.delete();
      waiting   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_START_ADDRESS) code_addr = cfg_wdata_i[ADDR_W-1:0];
        else if (cfg_index_i == CFG_NO_MULTIPLY) mul_off = cfg_wdata_i[0];
      end
      // retire before predicting: a request never completes in its own cycle
      if (res_valid_i && !res_stall_i) begin
        if (want_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result w1=%h w2=%h long=%b emit=%b addr=%h err=%0d",
                     res_i.first_word, res_i.second_word, res_i.is_long, res_i.emitted,
                     res_i.word_address, res_i.error);
        end else begin
          want = want_q.pop_front();
          if (res_i.first_word !== want.first_word || res_i.second_word !== want.second_word ||
              res_i.is_long !== want.is_long || res_i.emitted !== want.emitted ||
              res_i.word_address !== want.word_address || res_i.error !== want.error) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected w1=%h w2=%h long=%b emit=%b addr=%h err=%0d",
                       want.first_word, want.second_word, want.is_long, want.emitted,
                       want.word_address, want.error);
              $display("          got      w1=%h w2=%h long=%b emit=%b addr=%h err=%0d",
                       res_i.first_word, res_i.second_word, res_i.is_long, res_i.emitted,
                       res_i.word_address, res_i.error);
            end
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        want = encode_instr(req_i, code_addr, mul_off);
        want_q.push_back(want);
        if (want.emitted) code_addr = code_addr + (want.is_long ? 22'd2 : 22'd1);
      end
      waiting = want_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
// Top of the instruction encoder bench: clock, reset, request stimulus,
// configuration phases with random idling and stalls, and the verdict.
// Depends on aie_pkg, avr_instruction_encoder_unit and aie_result_check.

module testbench;
  import aie_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 128;
  localparam int PHASES       = 8;

  localparam logic [6:0] OP_NOP       = 7'd0;
  localparam logic [6:0] OP_BSET      = 7'd25;
  localparam logic [6:0] OP_BREQ      = 7'd42;
  localparam logic [6:0] OP_RJMP      = 7'd60;
  localparam logic [6:0] OP_JMP       = 7'd62;
  localparam logic [6:0] OP_BRBS      = 7'd64;
  localparam logic [6:0] OP_ADIW      = 7'd78;
  localparam logic [6:0] OP_SUBI      = 7'd80;
  localparam logic [6:0] OP_SBRC      = 7'd88;
  localparam logic [6:0] OP_IN        = 7'd92;
  localparam logic [6:0] OP_SBIC      = 7'd94;
  localparam logic [6:0] OP_LDS       = 7'd98;
  localparam logic [6:0] OP_UNUSED_LO = 7'd104;
  localparam logic [6:0] OP_UNUSED_HI = 7'd127;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  aie_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  aie_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                    fail_count;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_count = 0;
  logic [ADDR_W-1:0]     addr_guess = '0;
  aie_in_t               directed_q[$];

  always #2 clk = ~clk;

  avr_instruction_encoder_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  aie_result_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (in_valid),
    .req_stall_i  (in_stall),
    .req_i        (in_data),
    .res_valid_i  (out_valid),
    .res_stall_i  (out_stall),
    .res_i        (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic aie_in_t mk_instr(input logic [6:0] op, input logic [4:0] rd,
                                       input logic [4:0] rr, input logic [3:0] bn,
                                       input int val, input logic [3:0] pm, input logic uz);
    aie_in_t req;
    req.op           = op;
    req.data_reg     = rd;
    req.source_reg   = rr;
    req.bit_num      = bn;
    req.value        = val;
    req.pointer_mode = pm;
    req.use_z        = uz;
    return req;
  endfunction

  // values cluster around the branch windows and the field ranges
  function automatic aie_in_t random_instr(input logic [ADDR_W-1:0] near);
    aie_in_t req;
    req.op = ($urandom_range(0, 99) < 93) ? 7'($urandom_range(0, 103))
                                          : 7'($urandom_range(104, 127));
    req.data_reg   = 5'($urandom);
    req.source_reg = 5'($urandom);
    req.bit_num    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2: req.value = 32'(int'(near) + 1 + int'($urandom_range(0, 160)) - 80);
      3:       req.value = 32'(int'(near) + 1 + int'($urandom_range(0, 4400)) - 2200);
      4, 5, 6: req.value = 32'($urandom_range(0, 70));
      7:       req.value = 32'(int'($urandom_range(0, 400)) - 140);
      8:       req.value = 32'($urandom_range(0, 70000));
      default: req.value = $urandom();
    endcase
    req.pointer_mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
    req.use_z = 1'($urandom);
    return req;
  endfunction

  task automatic send_req(input aie_in_t req);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // decide at the falling edge, when stall is settled for the next edge
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (req.op == OP_JMP || req.op == OP_CALL || req.op == OP_LDS || req.op == OP_STS)
      addr_guess = addr_guess + 22'd2;
    else if (req.op <= OP_STD)
      addr_guess = addr_guess + 22'd1;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] start;
    directed_q.push_back(mk_instr(OP_NOP, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_BSET, 0, 0, 7, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_BCLR, 0, 0, 15, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_SER, 15, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_SER, 31, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_TST, 31, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_BREQ, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_BREQ, 0, 0, 0, 32'h7fffffff, 0, 0));
    directed_q.push_back(mk_instr(OP_RJMP, 0, 0, 0, -2000, 0, 0));
    directed_q.push_back(mk_instr(OP_RJMP, 0, 0, 0, 2100, 0, 0));
    directed_q.push_back(mk_instr(OP_JMP, 0, 0, 0, 4194303, 0, 0));
    directed_q.push_back(mk_instr(OP_CALL, 0, 0, 0, -1, 0, 0));
    directed_q.push_back(mk_instr(OP_BRBS, 0, 0, 15, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_MUL, 31, 31, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_ADIW, 25, 0, 0, 64, 0, 0));
    directed_q.push_back(mk_instr(OP_SUBI, 15, 0, 0, -129, 0, 0));
    directed_q.push_back(mk_instr(OP_CBR, 31, 0, 0, 255, 0, 0));
    directed_q.push_back(mk_instr(OP_SBRC, 31, 0, 8, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_IN, 31, 0, 0, 64, 0, 0));
    directed_q.push_back(mk_instr(OP_SBIC, 0, 0, 9, 32, 0, 0));
    directed_q.push_back(mk_instr(OP_CBI, 0, 0, 7, 31, 0, 0));
    directed_q.push_back(mk_instr(OP_LDS, 31, 0, 0, 65536, 0, 0));
    directed_q.push_back(mk_instr(OP_STS, 0, 0, 0, 65535, 0, 0));
    directed_q.push_back(mk_instr(OP_LD, 1, 0, 0, 0, 15, 0));
    directed_q.push_back(mk_instr(OP_LDD, 31, 0, 0, 63, 0, 1));
    directed_q.push_back(mk_instr(OP_STD, 0, 0, 0, -1, 0, 0));
    directed_q.push_back(mk_instr(OP_UNUSED_LO, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_instr(OP_UNUSED_HI, 31, 31, 15, -1, 15, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(CFG_START_ADDRESS, '0);
    cfg_write(CFG_NO_MULTIPLY, '0);
    addr_guess = '0;
    foreach (directed_q[i]) send_req(directed_q[i]);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) start = '0;
      else if (p == 1 || p == 5) start = 22'h3fffff;
      else if (p == 3) start = 22'h3fffc0;
      else start = 22'($urandom);
      cfg_write(CFG_START_ADDRESS, CFG_DATA_W'(start));
      cfg_write(CFG_NO_MULTIPLY, CFG_DATA_W'(((p + 1) >> 1) & 1));
      addr_guess = start;
      // no idling, sender idle, receiver stalls, both
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      repeat (PHASE_ITEMS) send_req(random_instr(addr_guess));
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
